### sv/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros shared by the RTL; compiled out with NO_ASSERTIONS.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, sampled on clk, off during reset.
`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication, sampled on clk, off during reset.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define ASSERT_IMPLIES(lbl, ante, cons, msg)
`define ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

### sv/fcce_pkg.sv
// ----------------------------------------------------------------------------
// fcce_pkg
// Types, codes and helpers for the FAT12 cluster chain engine.
// ----------------------------------------------------------------------------
package fcce_pkg;

  typedef logic [11:0] cluster_t;
  typedef logic [12:0] byte_off_t;
  typedef logic [7:0]  byte_t;

  localparam int unsigned TABLE_BYTES = 6144;

  localparam logic [1:0] FUNC_LOAD  = 2'd0;
  localparam logic [1:0] FUNC_READ  = 2'd1;
  localparam logic [1:0] FUNC_WALK  = 2'd2;
  localparam logic [1:0] FUNC_ALLOC = 2'd3;

  localparam logic CFG_DATA_BASE     = 1'b0;
  localparam logic CFG_CLUSTER_BYTES = 1'b1;

  localparam cluster_t END_MARK = 12'hFF8;
  localparam cluster_t BAD_MARK = 12'hFF7;

  localparam logic [23:0] DATA_BASE_RST     = 24'd16896;
  localparam logic [19:0] CLUSTER_BYTES_RST = 20'd512;

  // Byte offset of entry n: n * 3 / 2.
  function automatic byte_off_t entry_off(input cluster_t n);
    entry_off = {1'b0, n} + {2'b00, n[11:1]};
  endfunction

  // Unpack a 12-bit entry from its little-endian byte pair.
  function automatic cluster_t unpack(input byte_t lo, input byte_t hi, input logic odd);
    unpack = odd ? {hi, lo[7:4]} : {hi[3:0], lo};
  endfunction

endpackage

### sv/fcce_addr_unit.sv
// ----------------------------------------------------------------------------
// fcce_addr_unit
// Data byte address of a cluster: data_base + (cluster - 2) * cluster_bytes.
// ----------------------------------------------------------------------------
module fcce_addr_unit (
  input  logic              clk,
  input  fcce_pkg::cluster_t cluster,
  input  logic [23:0]       data_base,
  input  logic [19:0]       cluster_bytes,
  output logic [31:0]       byte_address
);

  logic signed [12:0] rel;
  logic signed [20:0] cb_s;
  logic signed [33:0] prod;
  logic [31:0]        prod_r;

  // Reserved clusters go negative and wrap modulo 2^32.
  assign rel  = $signed({1'b0, cluster}) - 13'sd2;
  assign cb_s = $signed({1'b0, cluster_bytes});
  assign prod = rel * cb_s;

  always_ff @(posedge clk) begin
    prod_r <= prod[31:0];
  end

  assign byte_address = {8'h00, data_base} + prod_r;

endmodule

### sv/fat12_cluster_chain_engine.sv
// ----------------------------------------------------------------------------
// fat12_cluster_chain_engine
// FAT12 table store with entry read, chain walk and free cluster allocation.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: drive in_func and its fields with start high; the word
//   is taken when busy is low. Load byte writes the table byte in that cycle
//   and gives no result; busy stays low.
//   Result channel: each result word sits on the out_ ports for one cycle,
//   marked by out_valid; out_last flags the final word of a command. The
//   receiver cannot stall, so results are never held back.
//   Config port: cfg_we with cfg_index and cfg_wdata; write only while idle.
// Sequencing:
//   Read entry: one word, after one table read, one unpack and one address add.
//   Walk chain: each cluster on the chain takes one table read, one
//   unpack and one address add, up to MAX_CHAIN words.
//   Allocate: the scan checks one entry per cycle through the table's
//   read port pair, from cluster 2 up; the first free cluster is taken,
//   and none_free is flagged when none is free.
// Reset: clears the sequencer and restores data_base and cluster_bytes.
//   The table store is not cleared; load it before use.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module fat12_cluster_chain_engine #(
  parameter int ENTRY_COUNT = 4096,
  parameter int MAX_CHAIN   = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  // command channel
  input  logic                start,
  output logic                busy,
  input  logic [1:0]          in_func,
  input  fcce_pkg::cluster_t  in_cluster,
  input  logic [12:0]         in_byte_index,
  input  logic [7:0]          in_byte_value,
  // result channel
  output logic                out_valid,
  output fcce_pkg::cluster_t  out_entry_value,
  output fcce_pkg::cluster_t  out_cluster_out,
  output logic [31:0]         out_byte_address,
  output logic                out_bad_cluster,
  output logic                out_none_free,
  output logic                out_truncated,
  output logic                out_last,
  // config port
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [23:0]         cfg_wdata
);

  localparam int CW = (MAX_CHAIN > 1) ? $clog2(MAX_CHAIN) : 1;
  localparam fcce_pkg::cluster_t LAST_CL   = 12'(ENTRY_COUNT - 1);
  localparam logic [CW-1:0]      LAST_STEP = CW'(MAX_CHAIN - 1);

  // sequencer states
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RD   = 3'd1;  // table read in flight
  localparam logic [2:0] S_ENT  = 3'd2;  // unpack entry
  localparam logic [2:0] S_OUT  = 3'd3;  // add address, emit word
  localparam logic [2:0] S_SCAN = 3'd4;  // free entry search
  localparam logic [2:0] S_AW1  = 3'd5;  // write low byte of new entry
  localparam logic [2:0] S_AW2  = 3'd6;  // write high byte of new entry

  logic [2:0]           state_r, state_nxt;
  logic [1:0]           op_r, op_nxt;
  fcce_pkg::cluster_t   cur_r, cur_nxt;
  fcce_pkg::cluster_t   chk_r, chk_nxt;
  fcce_pkg::cluster_t   entry_r, entry_nxt;
  logic [CW-1:0]        count_r, count_nxt;
  logic                 pend_r, pend_nxt;
  logic                 end_r, end_nxt;
  fcce_pkg::byte_t      wb0_r, wb0_nxt;
  fcce_pkg::byte_t      wb1_r, wb1_nxt;

  logic [23:0]          data_base_r;
  logic [19:0]          cluster_bytes_r;

  logic                 out_valid_r, out_valid_nxt;
  fcce_pkg::cluster_t   out_ev_r, out_ev_nxt;
  fcce_pkg::cluster_t   out_co_r, out_co_nxt;
  logic [31:0]          out_ba_r, out_ba_nxt;
  logic                 out_bad_r, out_bad_nxt;
  logic                 out_nf_r, out_nf_nxt;
  logic                 out_tr_r, out_tr_nxt;
  logic                 out_last_r, out_last_nxt;

  // table store
  fcce_pkg::byte_t      mem [fcce_pkg::TABLE_BYTES];
  fcce_pkg::byte_t      rd_lo_r, rd_hi_r;
  fcce_pkg::byte_off_t  rd_off;
  logic                 mem_we;
  fcce_pkg::byte_off_t  mem_waddr;
  fcce_pkg::byte_t      mem_wdata;

  logic                 accept;
  fcce_pkg::cluster_t   rd_entry;
  logic [31:0]          addr_val;

  assign accept   = start && (state_r == S_IDLE);
  assign busy     = (state_r != S_IDLE);
  assign rd_off   = fcce_pkg::entry_off(cur_r);
  assign rd_entry = fcce_pkg::unpack(rd_lo_r, rd_hi_r,
                                     (state_r == S_SCAN) ? chk_r[0] : cur_r[0]);

  fcce_addr_unit u_addr (
    .clk           (clk),
    .cluster       (cur_r),
    .data_base     (data_base_r),
    .cluster_bytes (cluster_bytes_r),
    .byte_address  (addr_val)
  );

  // Store write port: loads from idle, new entry bytes from allocate.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = in_byte_index;
    mem_wdata = in_byte_value;
    case (state_r)
      S_IDLE: begin
        mem_we = accept && (in_func == fcce_pkg::FUNC_LOAD) &&
                 (in_byte_index < 13'(fcce_pkg::TABLE_BYTES));
      end
      S_AW1: begin
        mem_we    = 1'b1;
        mem_waddr = rd_off;
        mem_wdata = wb0_r;
      end
      S_AW2: begin
        mem_we    = 1'b1;
        mem_waddr = rd_off + 13'd1;
        mem_wdata = wb1_r;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_lo_r <= mem[rd_off];
    rd_hi_r <= mem[rd_off + 13'd1];
  end

  // Sequencer
  always_comb begin
    state_nxt    = state_r;
    op_nxt       = op_r;
    cur_nxt      = cur_r;
    chk_nxt      = chk_r;
    entry_nxt    = entry_r;
    count_nxt    = count_r;
    pend_nxt     = pend_r;
    end_nxt      = end_r;
    wb0_nxt      = wb0_r;
    wb1_nxt      = wb1_r;
    out_valid_nxt = 1'b0;
    out_ev_nxt   = out_ev_r;
    out_co_nxt   = out_co_r;
    out_ba_nxt   = out_ba_r;
    out_bad_nxt  = out_bad_r;
    out_nf_nxt   = out_nf_r;
    out_tr_nxt   = out_tr_r;
    out_last_nxt = out_last_r;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          op_nxt    = in_func;
          cur_nxt   = in_cluster;
          count_nxt = '0;
          case (in_func)
            fcce_pkg::FUNC_READ: begin
              state_nxt = S_RD;
            end
            fcce_pkg::FUNC_WALK: begin
              if (in_cluster >= fcce_pkg::BAD_MARK) begin
                // start on an end or bad mark: one word, no table access
                out_valid_nxt = 1'b1;
                out_ev_nxt    = in_cluster;
                out_co_nxt    = in_cluster;
                out_ba_nxt    = '0;
                out_bad_nxt   = (in_cluster == fcce_pkg::BAD_MARK);
                out_nf_nxt    = 1'b0;
                out_tr_nxt    = 1'b0;
                out_last_nxt  = 1'b1;
              end else begin
                state_nxt = S_RD;
              end
            end
            fcce_pkg::FUNC_ALLOC: begin
              cur_nxt   = 12'd2;
              pend_nxt  = 1'b0;
              end_nxt   = 1'b0;
              state_nxt = S_SCAN;
            end
            default: begin
              state_nxt = S_IDLE;
            end
          endcase
        end
      end

      S_RD: begin
        state_nxt = S_ENT;
      end

      S_ENT: begin
        entry_nxt = rd_entry;
        state_nxt = S_OUT;
      end

      S_OUT: begin
        out_valid_nxt = 1'b1;
        out_ev_nxt    = entry_r;
        out_co_nxt    = cur_r;
        out_ba_nxt    = addr_val;
        out_bad_nxt   = 1'b0;
        out_nf_nxt    = 1'b0;
        out_tr_nxt    = 1'b0;
        out_last_nxt  = 1'b1;
        state_nxt     = S_IDLE;
        if (op_r == fcce_pkg::FUNC_WALK) begin
          if (entry_r >= fcce_pkg::END_MARK) begin
            out_last_nxt = 1'b1;
          end else if (entry_r == fcce_pkg::BAD_MARK) begin
            out_bad_nxt = 1'b1;
          end else if (count_r == LAST_STEP) begin
            out_tr_nxt = 1'b1;
          end else begin
            // follow the link
            out_last_nxt = 1'b0;
            count_nxt    = count_r + CW'(1);
            cur_nxt      = entry_r;
            state_nxt    = S_RD;
          end
        end
      end

      S_SCAN: begin
        if (pend_r && (rd_entry == '0)) begin
          // free entry: build its bytes, keep the neighbor nibble
          cur_nxt = chk_r;
          if (chk_r[0]) begin
            wb0_nxt = {fcce_pkg::END_MARK[3:0], rd_lo_r[3:0]};
            wb1_nxt = fcce_pkg::END_MARK[11:4];
          end else begin
            wb0_nxt = fcce_pkg::END_MARK[7:0];
            wb1_nxt = {rd_hi_r[7:4], fcce_pkg::END_MARK[11:8]};
          end
          entry_nxt = fcce_pkg::END_MARK;
          state_nxt = S_AW1;
        end else if (pend_r && (chk_r == LAST_CL)) begin
          out_valid_nxt = 1'b1;
          out_ev_nxt    = '0;
          out_co_nxt    = '0;
          out_ba_nxt    = '0;
          out_bad_nxt   = 1'b0;
          out_nf_nxt    = 1'b1;
          out_tr_nxt    = 1'b0;
          out_last_nxt  = 1'b1;
          state_nxt     = S_IDLE;
        end else begin
          // advance: the read issued now is checked next cycle
          pend_nxt = !end_r;
          chk_nxt  = cur_r;
          if (cur_r == LAST_CL) begin
            end_nxt = 1'b1;
          end else begin
            cur_nxt = cur_r + 12'd1;
          end
        end
      end

      S_AW1: begin
        state_nxt = S_AW2;
      end

      S_AW2: begin
        state_nxt = S_OUT;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      pend_r      <= 1'b0;
      end_r       <= 1'b0;
      count_r     <= '0;
      op_r        <= fcce_pkg::FUNC_LOAD;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      pend_r      <= pend_nxt;
      end_r       <= end_nxt;
      count_r     <= count_nxt;
      op_r        <= op_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r      <= cur_nxt;
    chk_r      <= chk_nxt;
    entry_r    <= entry_nxt;
    wb0_r      <= wb0_nxt;
    wb1_r      <= wb1_nxt;
    out_ev_r   <= out_ev_nxt;
    out_co_r   <= out_co_nxt;
    out_ba_r   <= out_ba_nxt;
    out_bad_r  <= out_bad_nxt;
    out_nf_r   <= out_nf_nxt;
    out_tr_r   <= out_tr_nxt;
    out_last_r <= out_last_nxt;
  end

  // Config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      data_base_r     <= fcce_pkg::DATA_BASE_RST;
      cluster_bytes_r <= fcce_pkg::CLUSTER_BYTES_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        fcce_pkg::CFG_DATA_BASE:     data_base_r     <= cfg_wdata;
        fcce_pkg::CFG_CLUSTER_BYTES: cluster_bytes_r <= cfg_wdata[19:0];
        default:                     data_base_r     <= data_base_r;
      endcase
    end
  end

  assign out_valid        = out_valid_r;
  assign out_entry_value  = out_ev_r;
  assign out_cluster_out  = out_co_r;
  assign out_byte_address = out_ba_r;
  assign out_bad_cluster  = out_bad_r;
  assign out_none_free    = out_nf_r;
  assign out_truncated    = out_tr_r;
  assign out_last         = out_last_r;

  // Checks
  `ASSERT_IMPLIES(a_flag_ends_item, out_valid && (out_bad_cluster || out_none_free || out_truncated), out_last, "flagged word without last")
  `ASSERT_IMPLIES(a_flags_exclusive, out_valid, !(out_truncated && out_bad_cluster), "truncated and bad together")
  `ASSERT_NEXT(a_read_goes_busy, accept && (in_func == fcce_pkg::FUNC_READ), busy, "read command left idle")
  `ASSERT_NEXT(a_alloc_write_pair, state_r == S_AW1, state_r == S_AW2, "allocate wrote one byte only")
  `ASSERT_IMPLIES(a_scan_no_result_early, state_r == S_SCAN && !pend_r, !out_valid_nxt, "scan emitted without data")

endmodule

### tb/sv/fat12_cluster_chain_engine_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fat12_cluster_chain_engine_tb
// Self-checking bench for the FAT12 cluster chain engine. The whole table is
// loaded first, so no entry is ever read unwritten. A short directed part
// follows, then four phases of random commands under different register
// settings. A table mirror predicts each result word, and every strobed word
// is checked against the oldest word still due.
// ----------------------------------------------------------------------------
module fat12_cluster_chain_engine_tb;
  import fcce_pkg::*;

  localparam int ENTRY_COUNT = 4096;
  localparam int MAX_CHAIN   = 64;
  localparam int TIMEOUT_NS  = 36_000_000;
  localparam int PHASE_OPS   = 35;

  typedef struct packed {
    logic [1:0]  func;
    cluster_t    cluster;
    logic [12:0] byte_index;
    byte_t       byte_value;
  } command_t;

  typedef struct packed {
    cluster_t    entry_value;
    cluster_t    cluster_out;
    logic [31:0] byte_address;
    logic        bad_cluster;
    logic        none_free;
    logic        truncated;
    logic        last;
  } result_t;

  // Mirror of the table store and registers; predicts the result words.
  class fat_mirror;
    byte_t       img [TABLE_BYTES];
    logic [23:0] data_base;
    logic [19:0] cluster_bytes;
    result_t     due[$];
    int          errors;

    function new();
      data_base     = DATA_BASE_RST;
      cluster_bytes = CLUSTER_BYTES_RST;
      errors        = 0;
      foreach (img[i]) img[i] = 8'h00;
    endfunction

    function void set_reg(logic idx, logic [23:0] v);
      if (idx == CFG_DATA_BASE) data_base = v;
      else cluster_bytes = v[19:0];
    endfunction

    function int pending();
      return due.size();
    endfunction

    function cluster_t entry_at(cluster_t n);
      byte_off_t   off;
      logic [15:0] w;
      off = {1'b0, n} + {2'b00, n[11:1]};
      w   = {img[off + 1], img[off]};
      return n[0] ? w[15:4] : w[11:0];
    endfunction

    function logic [31:0] cluster_addr(cluster_t n);
      return {8'd0, data_base} + ({20'd0, n} - 32'd2) * {12'd0, cluster_bytes};
    endfunction

    function void push(cluster_t ev, cluster_t co, logic [31:0] ba,
                       logic bad, logic nf, logic tr, logic lst);
      result_t r;
      r.entry_value  = ev;
      r.cluster_out  = co;
      r.byte_address = ba;
      r.bad_cluster  = bad;
      r.none_free    = nf;
      r.truncated    = tr;
      r.last         = lst;
      due.push_back(r);
    endfunction

    // Update the mirror for one accepted command and queue its result words.
    function void take_command(command_t c);
      cluster_t  cur, link;
      byte_off_t off;
      byte_t     lo, hi;
      int        k, i;
      bit        found;
      case (c.func)
        FUNC_LOAD: begin
          if (c.byte_index < TABLE_BYTES) img[c.byte_index] = c.byte_value;
        end
        FUNC_READ: begin
          push(entry_at(c.cluster), c.cluster, cluster_addr(c.cluster), 0, 0, 0, 1);
        end
        FUNC_WALK: begin
          cur = c.cluster;
          if (cur >= BAD_MARK) begin
            push(cur, cur, 32'd0, cur == BAD_MARK, 0, 0, 1);
          end else begin
            for (k = 0; k < MAX_CHAIN; k++) begin
              link = entry_at(cur);
              if (link >= END_MARK) begin
                push(link, cur, cluster_addr(cur), 0, 0, 0, 1);
                break;
              end else if (link == BAD_MARK) begin
                push(link, cur, cluster_addr(cur), 1, 0, 0, 1);
                break;
              end else if (k + 1 >= MAX_CHAIN) begin
                push(link, cur, cluster_addr(cur), 0, 0, 1, 1);
                break;
              end
              push(link, cur, cluster_addr(cur), 0, 0, 0, 0);
              cur = link;
            end
          end
        end
        default: begin
          found = 0;
          for (i = 2; i < ENTRY_COUNT; i++) begin
            cur = i[11:0];
            if (entry_at(cur) == 12'd0) begin
              off = {1'b0, cur} + {2'b00, cur[11:1]};
              lo  = img[off];
              hi  = img[off + 1];
              // keep the nibble that belongs to the neighbor entry
              if (cur[0]) begin
                img[off]     = {END_MARK[3:0], lo[3:0]};
                img[off + 1] = END_MARK[11:4];
              end else begin
                img[off]     = END_MARK[7:0];
                img[off + 1] = {hi[7:4], END_MARK[11:8]};
              end
              push(END_MARK, cur, cluster_addr(cur), 0, 0, 0, 1);
              found = 1;
              break;
            end
          end
          if (!found) push(12'd0, 12'd0, 32'd0, 0, 1, 0, 1);
        end
      endcase
    endfunction

    task report(string msg);
      if (errors < 100) $display("[%0t] MISMATCH %s", $time, msg);
      errors++;
    endtask

    task cmp_field(string name, logic [31:0] got, logic [31:0] want, cluster_t co);
      if (got !== want)
        report($sformatf("%s: got %0h, want %0h (cluster %0h)", name, got, want, co));
    endtask

    task check_word(result_t got);
      result_t want;
      if (due.size() == 0) begin
        report($sformatf("result word with none due (cluster %0h)", got.cluster_out));
        return;
      end
      want = due.pop_front();
      cmp_field("entry_value",  got.entry_value,  want.entry_value,  want.cluster_out);
      cmp_field("cluster_out",  got.cluster_out,  want.cluster_out,  want.cluster_out);
      cmp_field("byte_address", got.byte_address, want.byte_address, want.cluster_out);
      cmp_field("bad_cluster",  got.bad_cluster,  want.bad_cluster,  want.cluster_out);
      cmp_field("none_free",    got.none_free,    want.none_free,    want.cluster_out);
      cmp_field("truncated",    got.truncated,    want.truncated,    want.cluster_out);
      cmp_field("last",         got.last,         want.last,         want.cluster_out);
    endtask
  endclass

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [1:0]  in_func;
  cluster_t    in_cluster;
  logic [12:0] in_byte_index;
  logic [7:0]  in_byte_value;
  logic        out_valid;
  cluster_t    out_entry_value;
  cluster_t    out_cluster_out;
  logic [31:0] out_byte_address;
  logic        out_bad_cluster;
  logic        out_none_free;
  logic        out_truncated;
  logic        out_last;
  logic        cfg_we;
  logic        cfg_index;
  logic [23:0] cfg_wdata;

  fat_mirror sb = new();
  int        burst_left = 0;

  fat12_cluster_chain_engine u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_func          (in_func),
    .in_cluster       (in_cluster),
    .in_byte_index    (in_byte_index),
    .in_byte_value    (in_byte_value),
    .out_valid        (out_valid),
    .out_entry_value  (out_entry_value),
    .out_cluster_out  (out_cluster_out),
    .out_byte_address (out_byte_address),
    .out_bad_cluster  (out_bad_cluster),
    .out_none_free    (out_none_free),
    .out_truncated    (out_truncated),
    .out_last         (out_last),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  // Result words cannot be held off: check every strobed word at the edge
  // that ends its cycle.
  always @(posedge clk) begin
    result_t got;
    if (rst_n && out_valid) begin
      got.entry_value  = out_entry_value;
      got.cluster_out  = out_cluster_out;
      got.byte_address = out_byte_address;
      got.bad_cluster  = out_bad_cluster;
      got.none_free    = out_none_free;
      got.truncated    = out_truncated;
      got.last         = out_last;
      sb.check_word(got);
    end
  end

  function automatic command_t mk(logic [1:0] f, cluster_t c, logic [12:0] bi, byte_t bv);
    command_t cmd;
    cmd.func       = f;
    cmd.cluster    = c;
    cmd.byte_index = bi;
    cmd.byte_value = bv;
    return cmd;
  endfunction

  // Send one command word. Called at a clock edge. The sender runs in bursts;
  // between bursts it may drop start for a random gap. After the accept edge
  // start is left as it is, so a back-to-back word needs only one assignment
  // per edge.
  task automatic issue(input command_t c);
    int gap;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    start         <= 1'b1;
    in_func       <= c.func;
    in_cluster    <= c.cluster;
    in_byte_index <= c.byte_index;
    in_byte_value <= c.byte_value;
    do @(posedge clk); while (busy);
    sb.take_command(c);
  endtask

  // Hold off the sender until every due word has come, plus a small margin.
  task automatic settle();
    start <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Rewrite one table entry through two byte loads, keeping the neighbor
  // nibble of the shared byte as the mirror holds it.
  task automatic set_entry(input cluster_t n, input cluster_t v);
    byte_off_t off;
    byte_t     lo, hi;
    off = {1'b0, n} + {2'b00, n[11:1]};
    lo  = sb.img[off];
    hi  = sb.img[off + 1];
    if (n[0]) begin
      lo = {v[3:0], lo[3:0]};
      hi = v[11:4];
    end else begin
      lo = v[7:0];
      hi = {hi[7:4], v[11:8]};
    end
    issue(mk(FUNC_LOAD, 12'd0, off, lo));
    issue(mk(FUNC_LOAD, 12'd0, off + 13'd1, hi));
  endtask

  // Both registers, written while idle; the mirror follows each write edge.
  task automatic set_config(input logic [23:0] base, input logic [19:0] csize);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_DATA_BASE;
    cfg_wdata <= base;
    @(posedge clk);
    sb.set_reg(CFG_DATA_BASE, base);
    cfg_index <= CFG_CLUSTER_BYTES;
    cfg_wdata <= {4'd0, csize};
    @(posedge clk);
    sb.set_reg(CFG_CLUSTER_BYTES, {4'd0, csize});
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Lay a chain of distinct clusters into the table, close it with an end
  // mark, a bad mark or a loop back to its head, then walk it from the head.
  task automatic chain_walk();
    cluster_t nodes[$];
    cluster_t c;
    int       len, kind, j;
    bit       dup;
    len = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 70) : $urandom_range(1, 10);
    while (nodes.size() < len) begin
      c   = $urandom_range(0, 12'hFF6);
      dup = 0;
      foreach (nodes[i]) if (nodes[i] == c) dup = 1;
      if (!dup) nodes.push_back(c);
    end
    for (j = 0; j < len - 1; j++) set_entry(nodes[j], nodes[j + 1]);
    kind = $urandom_range(0, 9);
    if (kind < 6) set_entry(nodes[len - 1], END_MARK + cluster_t'($urandom_range(0, 7)));
    else if (kind < 8) set_entry(nodes[len - 1], BAD_MARK);
    else set_entry(nodes[len - 1], nodes[0]);
    issue(mk(FUNC_WALK, nodes[0], $urandom, $urandom));
  endtask

  task automatic random_op();
    int       pick;
    cluster_t c;
    pick = $urandom_range(0, 99);
    if (pick < 25) begin
      chain_walk();
    end else if (pick < 40) begin
      issue(mk(FUNC_READ, $urandom_range(0, 4095), $urandom, $urandom));
    end else if (pick < 55) begin
      // walk from wherever the table leads; now and then start on a mark
      if ($urandom_range(0, 4) == 0) c = $urandom_range(12'hFF7, 12'hFFF);
      else c = $urandom_range(0, 12'hFF6);
      issue(mk(FUNC_WALK, c, $urandom, $urandom));
    end else if (pick < 75) begin
      // raw byte load; a quarter of the indexes fall past the table
      issue(mk(FUNC_LOAD, $urandom, $urandom_range(0, 8191), $urandom_range(0, 255)));
    end else if (pick < 88) begin
      // free an entry, mostly low so the scan stays short, then allocate
      if ($urandom_range(0, 4) == 0) c = $urandom_range(2, 4095);
      else c = $urandom_range(2, 200);
      set_entry(c, 12'd0);
      issue(mk(FUNC_ALLOC, $urandom, $urandom, $urandom));
    end else begin
      issue(mk(FUNC_ALLOC, $urandom, $urandom, $urandom));
    end
    if ($urandom_range(0, 19) == 0) settle();
  endtask

  initial begin
    int       n, p, it, pick;
    cluster_t v;
    rst_n         = 1'b0;
    start         = 1'b0;
    in_func       = FUNC_LOAD;
    in_cluster    = '0;
    in_byte_index = '0;
    in_byte_value = '0;
    cfg_we        = 1'b0;
    cfg_index     = CFG_DATA_BASE;
    cfg_wdata     = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Fill every table byte. Entries 0 and 1 stay zero so allocate must skip
    // them; all others are nonzero: mostly links, some end and bad marks.
    for (n = 0; n < ENTRY_COUNT; n++) begin
      pick = $urandom_range(0, 99);
      if (n < 2) v = 12'd0;
      else if (pick < 12) v = END_MARK + cluster_t'($urandom_range(0, 7));
      else if (pick < 16) v = BAD_MARK;
      else v = $urandom_range(1, 4095);
      set_entry(n[11:0], v);
    end

    // Directed part, under the reset register values.
    issue(mk(FUNC_ALLOC, 12'd0, 13'd0, 8'd0));           // nothing free
    issue(mk(FUNC_READ, 12'd0, 13'd0, 8'd0));            // address below data base
    issue(mk(FUNC_READ, 12'd1, 13'd0, 8'd0));
    issue(mk(FUNC_READ, 12'hFFF, 13'd0, 8'd0));          // last bytes of store
    issue(mk(FUNC_WALK, BAD_MARK, 13'd0, 8'd0));         // start on bad mark
    issue(mk(FUNC_WALK, END_MARK, 13'd0, 8'd0));         // start on end mark
    issue(mk(FUNC_WALK, 12'hFFF, 13'd0, 8'd0));
    set_entry(12'hFFF, 12'd0);                           // odd free entry
    issue(mk(FUNC_ALLOC, 12'd0, 13'd0, 8'd0));
    set_entry(12'd2, 12'd0);                             // even free entry
    issue(mk(FUNC_ALLOC, 12'd0, 13'd0, 8'd0));
    issue(mk(FUNC_LOAD, 12'd0, 13'd6144, 8'hFF));        // past the table: drop
    issue(mk(FUNC_LOAD, 12'd0, 13'h1FFF, 8'h00));
    issue(mk(FUNC_READ, 12'hFFF, 13'd0, 8'd0));
    issue(mk(FUNC_LOAD, 12'd0, 13'd5, 8'h00));
    issue(mk(FUNC_LOAD, 12'd0, 13'd6, 8'hFF));
    issue(mk(FUNC_READ, 12'd3, 13'd0, 8'd0));
    issue(mk(FUNC_READ, 12'd4, 13'd0, 8'd0));
    set_entry(12'd10, 12'd11);
    set_entry(12'd11, 12'd12);
    set_entry(12'd12, 12'hFFF);
    issue(mk(FUNC_WALK, 12'd10, 13'd0, 8'd0));           // ends on end mark
    set_entry(12'd12, BAD_MARK);
    issue(mk(FUNC_WALK, 12'd10, 13'd0, 8'd0));           // ends on bad mark
    set_entry(12'd12, 12'd10);
    issue(mk(FUNC_WALK, 12'd10, 13'd0, 8'd0));           // loop: truncates

    // Random phases, each under its own register setting. Drain fully
    // before every register write.
    for (p = 0; p < 4; p++) begin
      settle();
      case (p)
        0: set_config(DATA_BASE_RST, CLUSTER_BYTES_RST);
        1: set_config(24'hFFFFFF, 20'd524288);
        2: set_config(24'd0, 20'd1);
        default: set_config($urandom, $urandom_range(1, 524288));
      endcase
      for (it = 0; it < PHASE_OPS; it++) random_op();
    end

    settle();
    repeat (16) @(posedge clk);
    if (sb.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Watchdog: a hung handshake or a lost word ends the run here.
  initial begin
    #(TIMEOUT_NS);
    $display("Test completed with failures");
    $finish;
  end

endmodule
